/* src/decaying_pair_coupling_table_unit_macros.svh */
`ifndef DECAYING_PAIR_COUPLING_TABLE_UNIT_MACROS_SVH
`define DECAYING_PAIR_COUPLING_TABLE_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define DPCT_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DPCT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/dpct_pkg.sv */
`default_nettype none

package dpct_pkg;

    // module index and q8.8 field widths as seen on the ports
    localparam int IDX_W   = 3;
    localparam int FIELD_W = 16;
    localparam int EVT_W   = 3;
    localparam int CMD_W   = 2;

    // configuration register indexes
    localparam logic [0:0] REG_BIND_THRESHOLD = 1'b0;
    localparam logic [0:0] REG_DECAY_RATE     = 1'b1;

    // input commands
    localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACTIVATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd3;

    // result event codes
    localparam logic [EVT_W-1:0] EV_DONE     = 3'd0;
    localparam logic [EVT_W-1:0] EV_NEW      = 3'd1;
    localparam logic [EVT_W-1:0] EV_BIND     = 3'd2;
    localparam logic [EVT_W-1:0] EV_UNBIND   = 3'd3;
    localparam logic [EVT_W-1:0] EV_COLLAPSE = 3'd4;
    localparam logic [EVT_W-1:0] EV_IGNORED  = 3'd5;

    // classified operation kinds handed from front to back
    localparam logic [1:0] OP_RESULT   = 2'd0;
    localparam logic [1:0] OP_ACTIVATE = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;
    localparam logic [1:0] OP_QUERY    = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [EVT_W-1:0]   ev;
        logic [IDX_W-1:0]   lo;
        logic [IDX_W-1:0]   hi;
        logic [FIELD_W-1:0] amount;
    } t_op;

    typedef struct packed {
        logic clearing;
        logic tick_active;
    } t_back_stat;

endpackage

`default_nettype wire

/* src/dpct_ram.sv */
`default_nettype none

module dpct_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 28
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* src/dpct_queue.sv */
`default_nettype none

module dpct_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire dpct_pkg::t_op i_op,
    output logic               o_full,
    input  wire logic          i_pop,
    output dpct_pkg::t_op      o_op,
    output logic               o_empty
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    dpct_pkg::t_op  r_mem [DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [PW:0]    r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_op    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

/* src/dpct_front.sv */
`default_nettype none

module dpct_front #(
    parameter int MODULES = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [dpct_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic [dpct_pkg::IDX_W-1:0]     i_a,
    input  wire logic [dpct_pkg::IDX_W-1:0]     i_b,
    input  wire logic [dpct_pkg::FIELD_W-1:0]   i_amount,
    input  wire logic                           i_q_full,
    input  wire dpct_pkg::t_back_stat           i_stat,
    output logic                                o_push,
    output dpct_pkg::t_op                       o_op
);

    localparam int KW = $clog2(MODULES);

    logic [MODULES-1:0]             r_known;
    logic [MODULES-1:0]             n_known;
    logic                           accept;
    logic [dpct_pkg::IDX_W-1:0]     lo;
    logic [dpct_pkg::IDX_W-1:0]     hi;
    logic                           a_in;
    logic                           lo_in;
    logic                           hi_in;
    logic                           known_a;
    logic                           known_lo;
    logic                           known_hi;
    logic                           pair_ok;

    assign o_ready = !i_q_full && !i_stat.clearing;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;

    assign lo = (i_a < i_b) ? i_a : i_b;
    assign hi = (i_a < i_b) ? i_b : i_a;

    assign a_in  = (32'(i_a) < MODULES);
    assign lo_in = (32'(lo) < MODULES);
    assign hi_in = (32'(hi) < MODULES);

    assign known_a  = a_in  ? r_known[KW'(i_a)] : 1'b0;
    assign known_lo = lo_in ? r_known[KW'(lo)]  : 1'b0;
    assign known_hi = hi_in ? r_known[KW'(hi)]  : 1'b0;

    assign pair_ok = (lo != hi) && hi_in;

    always_comb begin
        n_known     = r_known;
        o_op.kind   = dpct_pkg::OP_RESULT;
        o_op.ev     = dpct_pkg::EV_IGNORED;
        o_op.lo     = lo;
        o_op.hi     = hi;
        o_op.amount = i_amount;
        case (i_cmd)
            dpct_pkg::CMD_REGISTER: begin
                o_op.lo = i_a;
                o_op.hi = i_a;
                if (a_in) begin
                    o_op.ev = known_a ? dpct_pkg::EV_DONE : dpct_pkg::EV_NEW;
                    if (accept) begin
                        n_known[KW'(i_a)] = 1'b1;
                    end
                end
            end
            dpct_pkg::CMD_ACTIVATE: begin
                if (pair_ok && known_lo && known_hi) begin
                    o_op.kind = dpct_pkg::OP_ACTIVATE;
                end
            end
            dpct_pkg::CMD_TICK: begin
                o_op.kind = dpct_pkg::OP_TICK;
            end
            dpct_pkg::CMD_QUERY: begin
                if (pair_ok) begin
                    o_op.kind = dpct_pkg::OP_QUERY;
                end
            end
            default: begin
                o_op.kind = dpct_pkg::OP_RESULT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_known <= '0;
        end else begin
            r_known <= n_known;
        end
    end

endmodule

`default_nettype wire

/* src/dpct_back.sv */
`default_nettype none

module dpct_back #(
    parameter int MODULES     = 8,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_q_empty,
    input  wire dpct_pkg::t_op                  i_q_op,
    output logic                                o_q_pop,
    input  wire logic [dpct_pkg::FIELD_W-1:0]   i_bind_threshold,
    input  wire logic [dpct_pkg::FIELD_W-1:0]   i_decay_rate,
    output dpct_pkg::t_back_stat                o_stat,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [dpct_pkg::EVT_W-1:0]          o_m_ev,
    output logic [dpct_pkg::IDX_W-1:0]          o_m_lo,
    output logic [dpct_pkg::IDX_W-1:0]          o_m_hi,
    output logic [dpct_pkg::FIELD_W-1:0]        o_m_w,
    output logic                                o_m_b,
    output logic                                o_m_last
);

    localparam int PAIRS = MODULES * (MODULES - 1) / 2;
    localparam int SW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam int KW    = $clog2(MODULES);
    localparam int SUM_W = ((WEIGHT_BITS > dpct_pkg::FIELD_W) ? WEIGHT_BITS
                                                              : dpct_pkg::FIELD_W) + 1;
    localparam logic [SUM_W-1:0] WMAX       = SUM_W'({WEIGHT_BITS{1'b1}});
    localparam logic [SW-1:0]    LAST_SLOT  = SW'(PAIRS - 1);
    localparam logic [KW-1:0]    LAST_MOD   = KW'(MODULES - 1);
    localparam logic [KW-1:0]    LAST_OUTER = KW'(MODULES - 2);

    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_OUT   = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_EX    = 3'd4;
    localparam logic [2:0] ST_TRD   = 3'd5;
    localparam logic [2:0] ST_TEX   = 3'd6;
    localparam logic [2:0] ST_TDONE = 3'd7;

    logic [2:0]           r_state, n_state;
    dpct_pkg::t_op        r_op, n_op;
    logic [SW-1:0]        r_clr, n_clr;
    logic [KW-1:0]        r_i, n_i;
    logic [KW-1:0]        r_j, n_j;

    logic                            r_out_valid;
    logic [dpct_pkg::EVT_W-1:0]      r_out_ev;
    logic [dpct_pkg::IDX_W-1:0]      r_out_lo;
    logic [dpct_pkg::IDX_W-1:0]      r_out_hi;
    logic [dpct_pkg::FIELD_W-1:0]    r_out_w;
    logic                            r_out_b;
    logic                            r_out_last;

    logic                            emit;
    logic [dpct_pkg::EVT_W-1:0]      e_ev;
    logic [dpct_pkg::IDX_W-1:0]      e_lo;
    logic [dpct_pkg::IDX_W-1:0]      e_hi;
    logic [dpct_pkg::FIELD_W-1:0]    e_w;
    logic                            e_b;
    logic                            e_last;
    logic                            out_free;
    logic                            adv;

    logic [KW-1:0]        sel_lo;
    logic [KW-1:0]        sel_hi;
    logic [KW-1:0]        sel_hi_m1;
    logic [2*KW-1:0]      prod;
    logic [SW-1:0]        slot;

    logic                   ram_we;
    logic                   ram_re;
    logic [SW-1:0]          ram_waddr;
    logic [WEIGHT_BITS-1:0] ram_wdata;
    logic [WEIGHT_BITS-1:0] ram_q;

    logic [SUM_W-1:0]     w_ext;
    logic [SUM_W-1:0]     thr_ext;
    logic [SUM_W-1:0]     rate_ext;
    logic [SUM_W-1:0]     sum;
    logic [SUM_W-1:0]     act_w;
    logic [SUM_W-1:0]     dec_w;
    logic                 prior_bound;
    logic                 act_bound;
    logic                 dec_bound;

    // triangular slot number: hi * (hi - 1) / 2 + lo
    assign sel_lo    = (r_state == ST_TRD || r_state == ST_TEX) ? r_i : KW'(r_op.lo);
    assign sel_hi    = (r_state == ST_TRD || r_state == ST_TEX) ? r_j : KW'(r_op.hi);
    assign sel_hi_m1 = sel_hi - 1'b1;
    assign prod      = (2*KW)'(sel_hi) * (2*KW)'(sel_hi_m1);
    assign slot      = SW'(prod >> 1) + SW'(sel_lo);

    assign w_ext    = SUM_W'(ram_q);
    assign thr_ext  = SUM_W'(i_bind_threshold);
    assign rate_ext = SUM_W'(i_decay_rate);
    assign sum      = w_ext + SUM_W'(r_op.amount);
    assign act_w    = (sum > WMAX) ? WMAX : sum;
    assign dec_w    = (w_ext > rate_ext) ? (w_ext - rate_ext) : '0;

    // zero weight never counts as bound
    assign prior_bound = (w_ext != '0) && (w_ext >= thr_ext);
    assign act_bound   = (act_w != '0) && (act_w >= thr_ext);
    assign dec_bound   = (dec_w != '0) && (dec_w >= thr_ext);

    assign out_free = !r_out_valid || i_m_tready;

    assign ram_waddr = (r_state == ST_CLR) ? r_clr : slot;
    assign ram_wdata = (r_state == ST_CLR) ? '0 :
                       (r_state == ST_EX)  ? WEIGHT_BITS'(act_w) : WEIGHT_BITS'(dec_w);

    dpct_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (PAIRS)
    ) u_weights (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (slot),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_clr   = r_clr;
        n_i     = r_i;
        n_j     = r_j;
        ram_we  = 1'b0;
        ram_re  = 1'b0;
        o_q_pop = 1'b0;
        emit    = 1'b0;
        adv     = 1'b0;
        e_ev    = dpct_pkg::EV_DONE;
        e_lo    = '0;
        e_hi    = '0;
        e_w     = '0;
        e_b     = 1'b0;
        e_last  = 1'b1;
        case (r_state)
            ST_CLR: begin
                ram_we = 1'b1;
                if (r_clr == LAST_SLOT) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_op    = i_q_op;
                    case (i_q_op.kind)
                        dpct_pkg::OP_RESULT: n_state = ST_OUT;
                        dpct_pkg::OP_TICK: begin
                            n_i     = '0;
                            n_j     = KW'(1);
                            n_state = ST_TRD;
                        end
                        default: n_state = ST_RD;
                    endcase
                end
            end
            ST_OUT: begin
                emit = 1'b1;
                e_ev = r_op.ev;
                e_lo = r_op.lo;
                e_hi = r_op.hi;
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RD: begin
                ram_re  = 1'b1;
                n_state = ST_EX;
            end
            ST_EX: begin
                emit = 1'b1;
                e_lo = r_op.lo;
                e_hi = r_op.hi;
                if (r_op.kind == dpct_pkg::OP_ACTIVATE) begin
                    e_w    = dpct_pkg::FIELD_W'(act_w);
                    e_b    = act_bound;
                    e_ev   = (!prior_bound && act_bound) ? dpct_pkg::EV_BIND
                                                         : dpct_pkg::EV_DONE;
                    ram_we = out_free;
                end else begin
                    e_w = dpct_pkg::FIELD_W'(w_ext);
                    e_b = prior_bound;
                end
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_TRD: begin
                ram_re  = 1'b1;
                n_state = ST_TEX;
            end
            ST_TEX: begin
                e_lo   = dpct_pkg::IDX_W'(r_i);
                e_hi   = dpct_pkg::IDX_W'(r_j);
                e_last = 1'b0;
                if (w_ext != '0 && prior_bound && dec_w == '0) begin
                    emit = 1'b1;
                    e_ev = dpct_pkg::EV_COLLAPSE;
                end else if (w_ext != '0 && prior_bound && !dec_bound) begin
                    emit = 1'b1;
                    e_ev = dpct_pkg::EV_UNBIND;
                    e_w  = dpct_pkg::FIELD_W'(dec_w);
                end
                adv    = !emit || out_free;
                ram_we = (w_ext != '0) && adv;
                if (adv) begin
                    n_state = ST_TRD;
                    if (r_j == LAST_MOD) begin
                        if (r_i == LAST_OUTER) begin
                            n_state = ST_TDONE;
                        end else begin
                            n_i = r_i + 1'b1;
                            n_j = r_i + KW'(2);
                        end
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            ST_TDONE: begin
                emit = 1'b1;
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_clr       <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_i     <= n_i;
            r_j     <= n_j;
            if (emit && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
        if (emit && out_free) begin
            r_out_ev   <= e_ev;
            r_out_lo   <= e_lo;
            r_out_hi   <= e_hi;
            r_out_w    <= e_w;
            r_out_b    <= e_b;
            r_out_last <= e_last;
        end
    end

    assign o_stat.clearing    = (r_state == ST_CLR);
    assign o_stat.tick_active = (r_state == ST_TRD) || (r_state == ST_TEX)
                                || (r_state == ST_TDONE);

    assign o_m_tvalid = r_out_valid;
    assign o_m_ev     = r_out_ev;
    assign o_m_lo     = r_out_lo;
    assign o_m_hi     = r_out_hi;
    assign o_m_w      = r_out_w;
    assign o_m_b      = r_out_b;
    assign o_m_last   = r_out_last;

endmodule

`default_nettype wire

/* src/decaying_pair_coupling_table_unit.sv */
// channel   dir  handshake                    tuser (low bit up)   tdata (low bit up)
// s_axis    in   s_axis_tvalid/s_axis_tready  cmd                  module_a, module_b, amount
// m_axis    out  m_axis_tvalid/m_axis_tready  event_res            pair_low, pair_high,
//                                                                  weight_now, is_bound_now
// cfg       in   i_cfg_we (no wait)           -                    i_cfg_idx, i_cfg_data
//
// register and ignored commands: queue pop, then result into output register
// activate and query: queue pop, registered ram read, then result and, for activate, write-back
// tick: pop, then a ram read and a decay step per pair over MODULES*(MODULES-1)/2 pairs, then the done result
// after reset a clearing pass zeroes the weight ram, one entry a cycle over all
//   MODULES*(MODULES-1)/2 entries, with s_axis_tready low meanwhile
// a two-entry queue parts the front from the back, and the output register takes a
//   new result in the cycle the previous one leaves, so either side may stall alone
`default_nettype none

`include "decaying_pair_coupling_table_unit_macros.svh"

module decaying_pair_coupling_table_unit #(
    parameter int MODULES     = 8,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input transfers
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // module_a[2:0], module_b[5:3], amount[21:6]
    input  wire logic [1:0]  s_axis_tuser,   // cmd[1:0]
    // result transfers
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // pair_low[2:0], pair_high[5:3],
                                             // weight_now[21:6], is_bound_now[22]
    output logic [2:0]       m_axis_tuser,   // event_res[2:0]
    output logic             m_axis_tlast,   // last result of the command
    // configuration writes
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    // configuration register reset values
    localparam logic [15:0] BIND_THRESHOLD_RST = 16'd256;
    localparam logic [15:0] DECAY_RATE_RST     = 16'd26;

    logic [dpct_pkg::FIELD_W-1:0] r_bind_threshold;
    logic [dpct_pkg::FIELD_W-1:0] r_decay_rate;

    logic                         push;
    dpct_pkg::t_op                push_op;
    logic                         q_full;
    logic                         q_empty;
    logic                         q_pop;
    dpct_pkg::t_op                q_op;
    dpct_pkg::t_back_stat         stat;

    logic [dpct_pkg::IDX_W-1:0]   out_lo;
    logic [dpct_pkg::IDX_W-1:0]   out_hi;
    logic [dpct_pkg::FIELD_W-1:0] out_w;
    logic                         out_b;

    // config writes land at once; the user must write them only while the block is idle, which it does not enforce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bind_threshold <= BIND_THRESHOLD_RST;
            r_decay_rate     <= DECAY_RATE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dpct_pkg::REG_BIND_THRESHOLD: r_bind_threshold <= i_cfg_data;
                dpct_pkg::REG_DECAY_RATE:     r_decay_rate     <= i_cfg_data;
                default: begin
                    r_bind_threshold <= r_bind_threshold;
                end
            endcase
        end
    end

    // front: module registry and command classification
    dpct_front #(
        .MODULES (MODULES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_cmd    (s_axis_tuser),
        .i_a      (s_axis_tdata[2:0]),
        .i_b      (s_axis_tdata[5:3]),
        .i_amount (s_axis_tdata[21:6]),
        .i_q_full (q_full),
        .i_stat   (stat),
        .o_push   (push),
        .o_op     (push_op)
    );

    // short queue of classified operations
    dpct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_op    (q_op),
        .o_empty (q_empty)
    );

    // back: weight ram, read-modify-write and tick walk, output register
    dpct_back #(
        .MODULES     (MODULES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_q_op           (q_op),
        .o_q_pop          (q_pop),
        .i_bind_threshold (r_bind_threshold),
        .i_decay_rate     (r_decay_rate),
        .o_stat           (stat),
        .o_m_tvalid       (m_axis_tvalid),
        .i_m_tready       (m_axis_tready),
        .o_m_ev           (m_axis_tuser),
        .o_m_lo           (out_lo),
        .o_m_hi           (out_hi),
        .o_m_w            (out_w),
        .o_m_b            (out_b),
        .o_m_last         (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, out_b, out_w, out_hi, out_lo};

    // no result can be pending while the ram is still being cleared
    `DPCT_ASSERT_NOW(a_clear_quiet, i_clk, i_rst_n, stat.clearing, !m_axis_tvalid, "result during clearing pass")

    // a collapse reports zero weight and never closes the command
    `DPCT_ASSERT_NOW(a_collapse_form, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == dpct_pkg::EV_COLLAPSE, m_axis_tdata[21:6] == '0 && !m_axis_tdata[22] && !m_axis_tlast, "bad collapse result")

    // a bind only comes from an activate, which is bound and closes its command
    `DPCT_ASSERT_NOW(a_bind_form, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == dpct_pkg::EV_BIND, m_axis_tdata[22] && m_axis_tlast, "bad bind result")

    // after a non-final tick result leaves, the walk goes on or its done result waits
    `DPCT_ASSERT_NEXT(a_tick_continues, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, stat.tick_active || (m_axis_tvalid && m_axis_tlast), "tick walk ended without done result")

endmodule

`default_nettype wire
